### rtl/top_k_largest_min_heap_assert.svh
// ----------------------------------------------------------------------------
// Top-K largest selector: assertion macros
// Concurrent check macros shared by the RTL files. They expand to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TOP_K_LARGEST_MIN_HEAP_ASSERT_SVH
`define TOP_K_LARGEST_MIN_HEAP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication under an active-low reset.
`define TKMH_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
// Next-cycle implication under an active-low reset.
`define TKMH_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define TKMH_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TKMH_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

### rtl/tkmh_pkg.sv
// ----------------------------------------------------------------------------
// Top-K largest selector: package
// Field widths, defaults, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tkmh_pkg;

    localparam int KEY_W        = 16;
    localparam int TAG_W        = 32;
    localparam int ENTRY_W      = KEY_W + TAG_W;
    localparam int KEEP_W       = 7;
    localparam int MAX_KEEP_DEF = 64;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd50;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ITEM,
        ST_HEAP_NEXT,
        ST_HEAP_LOAD,
        ST_ROOT_CMP,
        ST_SIFT_RD,
        ST_SIFT_CMP,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef struct packed {
        logic cfg_write;
        logic load_item;
        logic append;
        logic heap_init;
        logic heap_dec_read;
        logic carry_from_rd;
        logic set_heaped;
        logic rd_root;
        logic carry_item;
        logic rd_children;
        logic sift_step;
        logic write_carried;
        logic rd_emit;
        logic out_load;
        logic list_clear;
    } cmd_t;

    typedef struct packed {
        logic below_k;
        logic heaped;
        logic item_last;
        logic root_less;
        logic sift_stop;
        logic hi_zero;
        logic out_free;
        logic emit_final;
    } status_t;

endpackage

### rtl/tkmh_dp.sv
// ----------------------------------------------------------------------------
// Top-K largest selector: datapath
// Entry store with two registered read ports, item and carry registers,
// sift-down comparators and the output register.
// ----------------------------------------------------------------------------
module tkmh_dp #(
    parameter int MAX_KEEP = tkmh_pkg::MAX_KEEP_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tkmh_pkg::cmd_t                cmd,
    output tkmh_pkg::status_t             status,
    input  logic [tkmh_pkg::KEEP_W-1:0]   cfg_data,
    input  logic [tkmh_pkg::ENTRY_W-1:0]  s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tkmh_pkg::ENTRY_W-1:0]  m_tdata,
    output logic                          m_tlast
);
    import tkmh_pkg::*;

    localparam int AW = $clog2(MAX_KEEP);
    localparam int CW = $clog2(MAX_KEEP + 1);
    localparam int LW = AW + 2;

    // Entry layout matches the stream: key in the low bits, tag above it.
    logic [ENTRY_W-1:0] mem [MAX_KEEP];
    logic [ENTRY_W-1:0] rd_a_reg, rd_b_reg;

    logic [KEEP_W-1:0]  keep_reg, keep_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               heaped_reg, heaped_next;
    logic               out_valid_reg, out_valid_next;
    logic [ENTRY_W-1:0] item_reg, item_next;
    logic               last_reg, last_next;
    logic [ENTRY_W-1:0] carry_reg, carry_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [AW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]      ei_reg, ei_next;
    logic [ENTRY_W-1:0] out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;

    logic [CW-1:0]      k_eff;
    logic [LW-1:0]      lc, rc;
    logic               lc_ok, rc_ok, sel_l, sel_r;
    logic [KEY_W-1:0]   min_key;
    logic [AW-1:0]      child_idx;
    logic [ENTRY_W-1:0] child_ent;
    logic [AW-1:0]      addr_a, addr_b, waddr;
    logic               we;
    logic [ENTRY_W-1:0] wdata;
    logic               emit_final;

    // Out-of-range register values are clamped to 1..MAX_KEEP.
    always_comb begin
        if (keep_reg == '0) begin
            k_eff = CW'(1);
        end else if (keep_reg > KEEP_W'(MAX_KEEP)) begin
            k_eff = CW'(MAX_KEEP);
        end else begin
            k_eff = CW'(keep_reg);
        end
    end

    assign lc    = {1'b0, pos_reg, 1'b1};
    assign rc    = {1'b0, pos_reg, 1'b0} + LW'(2);
    assign lc_ok = lc < LW'(k_eff);
    assign rc_ok = rc < LW'(k_eff);

    // Pick the smallest of carried entry and children; ties keep the parent.
    assign sel_l     = lc_ok && (rd_a_reg[KEY_W-1:0] < carry_reg[KEY_W-1:0]);
    assign min_key   = sel_l ? rd_a_reg[KEY_W-1:0] : carry_reg[KEY_W-1:0];
    assign sel_r     = rc_ok && (rd_b_reg[KEY_W-1:0] < min_key);
    assign child_idx = sel_r ? rc[AW-1:0] : lc[AW-1:0];
    assign child_ent = sel_r ? rd_b_reg : rd_a_reg;

    assign emit_final = (CW'(ei_reg) + CW'(1)) == count_reg;

    always_comb begin
        status.below_k    = count_reg < k_eff;
        status.heaped     = heaped_reg;
        status.item_last  = last_reg;
        status.root_less  = item_reg[KEY_W-1:0] > rd_a_reg[KEY_W-1:0];
        status.sift_stop  = !sel_l && !sel_r;
        status.hi_zero    = hi_reg == '0;
        status.out_free   = !out_valid_reg || m_tready;
        status.emit_final = emit_final;
    end

    always_comb begin
        if (cmd.heap_dec_read) begin
            addr_a = hi_reg - AW'(1);
        end else if (cmd.rd_children) begin
            addr_a = lc[AW-1:0];
        end else if (cmd.rd_emit) begin
            addr_a = ei_reg;
        end else if (cmd.rd_root) begin
            addr_a = '0;
        end else begin
            addr_a = '0;
        end
        addr_b = rc[AW-1:0];
    end

    always_comb begin
        we    = 1'b0;
        waddr = pos_reg;
        wdata = carry_reg;
        if (cmd.append) begin
            we    = 1'b1;
            waddr = count_reg[AW-1:0];
            wdata = item_reg;
        end else if (cmd.sift_step) begin
            we    = 1'b1;
            wdata = child_ent;
        end else if (cmd.write_carried) begin
            we    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    always_comb begin
        keep_next      = keep_reg;
        count_next     = count_reg;
        heaped_next    = heaped_reg;
        out_valid_next = out_valid_reg;
        item_next      = item_reg;
        last_next      = last_reg;
        carry_next     = carry_reg;
        pos_next       = pos_reg;
        hi_next        = hi_reg;
        ei_next        = ei_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        if (cmd.cfg_write) begin
            keep_next   = cfg_data;
            count_next  = '0;
            heaped_next = 1'b0;
        end
        if (cmd.load_item) begin
            item_next = s_tdata;
            last_next = s_tlast;
            ei_next   = '0;
        end
        if (cmd.append) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.heap_init) begin
            hi_next = AW'(k_eff >> 1);
        end
        if (cmd.heap_dec_read) begin
            hi_next = hi_reg - AW'(1);
        end
        if (cmd.carry_from_rd) begin
            carry_next = rd_a_reg;
            pos_next   = hi_reg;
        end
        if (cmd.set_heaped) begin
            heaped_next = 1'b1;
        end
        if (cmd.carry_item) begin
            carry_next = item_reg;
            pos_next   = '0;
        end
        if (cmd.sift_step) begin
            pos_next = child_idx;
        end
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_data_next  = rd_a_reg;
            out_last_next  = emit_final;
            ei_next        = ei_reg + AW'(1);
        end
        if (cmd.list_clear) begin
            count_next  = '0;
            heaped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg      <= KEEP_RESET;
            count_reg     <= '0;
            heaped_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            keep_reg      <= keep_next;
            count_reg     <= count_next;
            heaped_reg    <= heaped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        last_reg     <= last_next;
        carry_reg    <= carry_next;
        pos_reg      <= pos_next;
        hi_reg       <= hi_next;
        ei_reg       <= ei_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

### rtl/tkmh_ctrl.sv
// ----------------------------------------------------------------------------
// Top-K largest selector: controller
// Sequences append, heap build, root replacement with sift-down, and the
// read-out of the retained entries.
// ----------------------------------------------------------------------------
module tkmh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  tkmh_pkg::status_t status,
    output tkmh_pkg::cmd_t    cmd
);
    import tkmh_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        cfg_ready  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_tready  = !cfg_valid;
                if (cfg_valid) begin
                    cmd.cfg_write = 1'b1;
                end else if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_ITEM;
                end
            end
            ST_ITEM: begin
                if (status.below_k) begin
                    cmd.append = 1'b1;
                    state_next = status.item_last ? ST_EMIT_RD : ST_IDLE;
                end else if (!status.heaped) begin
                    cmd.heap_init = 1'b1;
                    state_next    = ST_HEAP_NEXT;
                end else begin
                    cmd.rd_root = 1'b1;
                    state_next  = ST_ROOT_CMP;
                end
            end
            ST_HEAP_NEXT: begin
                if (status.hi_zero) begin
                    cmd.set_heaped = 1'b1;
                    cmd.rd_root    = 1'b1;
                    state_next     = ST_ROOT_CMP;
                end else begin
                    cmd.heap_dec_read = 1'b1;
                    state_next        = ST_HEAP_LOAD;
                end
            end
            ST_HEAP_LOAD: begin
                cmd.carry_from_rd = 1'b1;
                state_next        = ST_SIFT_RD;
            end
            ST_ROOT_CMP: begin
                if (status.root_less) begin
                    cmd.carry_item = 1'b1;
                    state_next     = ST_SIFT_RD;
                end else begin
                    state_next = status.item_last ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_SIFT_RD: begin
                cmd.rd_children = 1'b1;
                state_next      = ST_SIFT_CMP;
            end
            ST_SIFT_CMP: begin
                if (!status.sift_stop) begin
                    cmd.sift_step = 1'b1;
                    state_next    = ST_SIFT_RD;
                end else begin
                    cmd.write_carried = 1'b1;
                    if (!status.heaped) begin
                        state_next = ST_HEAP_NEXT;
                    end else begin
                        state_next = status.item_last ? ST_EMIT_RD : ST_IDLE;
                    end
                end
            end
            ST_EMIT_RD: begin
                if (status.out_free) begin
                    cmd.rd_emit = 1'b1;
                    state_next  = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                cmd.out_load = 1'b1;
                if (status.emit_final) begin
                    cmd.list_clear = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/top_k_largest_min_heap.sv
// ----------------------------------------------------------------------------
// Top-K largest selector with a min-heap
// Keeps the K entries with the largest keys out of a list of key and tag
// pairs and streams them out after the last item of the list.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  cfg_*     in         cfg_valid / cfg_ready  keep_count (K)
//  s_*       in         s_tvalid / s_tready    key, tag; last_item on s_tlast
//  m_*       out        m_tvalid / m_tready    kept_key, kept_tag; final_entry on m_tlast
//
//  While fewer than K entries are held, an item is accepted and then appended to the
//  store. Once the store is full, an item that does not beat the root is dropped, and
//  one that replaces the root is sifted down, at most 6 heap levels for K = 64; at
//  each level the sift-down reads both children, then compares and writes back.
//  The first item past K also pays for the heap build, one sift-down for each
//  of the K/2 inner nodes. Each retained entry is read from the store and then
//  loaded into the output register. Reset is synchronous and active low; the store
//  itself is not cleared. A stalled m_tready holds the read-out; the last result may
//  still wait in the output register while the next transaction is accepted on s_*.
//
module top_k_largest_min_heap #(
    parameter int MAX_KEEP = tkmh_pkg::MAX_KEEP_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write channel: keep_count.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tkmh_pkg::KEEP_W-1:0]   cfg_data,
    // Input items.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tkmh_pkg::ENTRY_W-1:0]  s_tdata,   // [15:0] key, [47:16] tag
    input  logic                          s_tlast,   // last_item
    // Retained entries.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tkmh_pkg::ENTRY_W-1:0]  m_tdata,   // [15:0] kept_key, [47:16] kept_tag
    output logic                          m_tlast    // final_entry
);
    import tkmh_pkg::*;

`include "top_k_largest_min_heap_assert.svh"

    cmd_t    cmd;
    status_t status;

    // The controller only sequences; all storage and compares sit in the datapath.
    tkmh_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tkmh_dp #(
        .MAX_KEEP (MAX_KEEP)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // A configuration write and an item transaction never land on the same edge.
    `TKMH_ASSERT_IMP(a_cfg_item_excl, aclk, aresetn, s_tvalid && s_tready, !(cfg_valid && cfg_ready))

    // One item at a time: after an item is taken the input side closes.
    `TKMH_ASSERT_NXT(a_item_closes, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // The output register is always empty when a new entry is loaded into it.
    `TKMH_ASSERT_IMP(a_out_free_on_load, aclk, aresetn, cmd.out_load, !m_tvalid)

endmodule
